// ----- rtl/core/sled_pkg.sv -----
`default_nettype none

package sled_pkg;

   localparam int DAY_MINUTES            = 1440;
   localparam int DEF_INTERVAL_COUNT     = 4;
   localparam int DEF_RAMP_STEP_TICKS    = 2;
   localparam int MAX_INTERVAL_COUNT     = 4;

   localparam int MINUTE_W   = 11;
   localparam int TICK_W     = 16;
   localparam int DUTY_W     = 8;
   localparam int SWITCH_W   = 21;
   localparam int INTERVAL_W = 43;
   localparam int CSR_IDX_W  = 3;
   localparam int TIMER_W    = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_ENABLED        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCHEDULER_MODE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET         = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL_BASE  = 3'd3;

   localparam logic [1:0] SW_FIXED   = 2'd0;
   localparam logic [1:0] SW_SUNRISE = 2'd1;
   localparam logic [1:0] SW_SUNSET  = 2'd2;

   typedef struct packed {
      logic [MINUTE_W-1:0] minutes_now;
      logic [MINUTE_W-1:0] sunrise_minute;
      logic [MINUTE_W-1:0] sunset_minute;
      logic                on_battery;
      logic [TICK_W-1:0]   tick_count;
      logic                toggle_request;
      logic                update_request;
   } req_type;

   typedef struct packed {
      logic              state_changed;
      logic              output_on;
      logic              target_state;
      logic              duty_load;
      logic [DUTY_W-1:0] duty_value;
      logic              ramping;
   } rsp_type;

   function automatic logic [MINUTE_W-1:0] sun_time(logic [MINUTE_W-1:0] ev,
                                                    logic [7:0] off);
      logic signed [12:0] t;
      logic signed [12:0] day;
      begin
         day = 13'(DAY_MINUTES);
         t   = signed'({2'b00, ev}) + signed'({{5{off[7]}}, off});
         if (t < 13'sd0) begin
            sun_time = MINUTE_W'(t + day);
         end else if (t >= day) begin
            sun_time = MINUTE_W'(t - day);
         end else begin
            sun_time = MINUTE_W'(t);
         end
      end
   endfunction

   function automatic logic [MINUTE_W-1:0] switch_time(logic [SWITCH_W-1:0] sw,
                                                       logic [MINUTE_W-1:0] rise,
                                                       logic [MINUTE_W-1:0] set);
      begin
         case (sw[20:19])
            SW_FIXED:   switch_time = sw[18:8];
            SW_SUNRISE: switch_time = sun_time(rise, sw[7:0]);
            SW_SUNSET:  switch_time = sun_time(set, sw[7:0]);
            default:    switch_time = '0;
         endcase
      end
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/sled_sched.sv -----
`default_nettype none

module sled_sched #(
   parameter int INTERVAL_COUNT = sled_pkg::DEF_INTERVAL_COUNT
) (
   input  wire logic [INTERVAL_COUNT-1:0][sled_pkg::INTERVAL_W-1:0] intervals,
   input  wire logic                                               scheduler_mode,
   input  wire logic [sled_pkg::MINUTE_W-1:0]                      minutes_now,
   input  wire logic [sled_pkg::MINUTE_W-1:0]                      sunrise_minute,
   input  wire logic [sled_pkg::MINUTE_W-1:0]                      sunset_minute,
   output logic                                                    schedule_on
);

   logic [INTERVAL_COUNT-1:0] hit;

   always_comb begin
      for (int i = 0; i < INTERVAL_COUNT; i++) begin
         logic [sled_pkg::MINUTE_W-1:0] on_t;
         logic [sled_pkg::MINUTE_W-1:0] off_t;
         on_t  = sled_pkg::switch_time(intervals[i][41:21], sunrise_minute, sunset_minute);
         off_t = sled_pkg::switch_time(intervals[i][20:0], sunrise_minute, sunset_minute);
         if (on_t <= off_t) begin
            hit[i] = intervals[i][42] && (minutes_now >= on_t) && (minutes_now < off_t);
         end else begin
            hit[i] = intervals[i][42] && ((minutes_now >= on_t) || (minutes_now < off_t));
         end
      end
   end

   assign schedule_on = !scheduler_mode && (|hit);

endmodule

`default_nettype wire

// ----- rtl/core/sled_ctrl.sv -----
`default_nettype none

module sled_ctrl #(
   parameter int RAMP_STEP_TICKS = sled_pkg::DEF_RAMP_STEP_TICKS
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        fire,
   input  wire sled_pkg::req_type           item,
   input  wire logic                        schedule_in,
   input  wire logic                        enabled,
   input  wire logic [sled_pkg::DUTY_W-1:0] target_brightness,
   output sled_pkg::rsp_type                result
);

   localparam logic [sled_pkg::TIMER_W-1:0] STEP_RELOAD = sled_pkg::TIMER_W'(RAMP_STEP_TICKS);

   logic                              override_ff, override_in;
   logic                              prev_out_ff, prev_out_in;
   logic                              force_ff, force_in;
   logic                              sched_ff, sched_in;
   logic                              prev_sched_ff, prev_sched_in;
   logic                              ramp_ff, ramp_in;
   logic [sled_pkg::DUTY_W-1:0]       level_ff, level_in;
   logic [sled_pkg::TIMER_W-1:0]      timer_ff, timer_in;
   logic [sled_pkg::TICK_W-1:0]       tick_ff, tick_in;

   always_comb begin
      logic ovr;
      logic fp;
      logic outst;
      logic upd;
      override_in   = override_ff;
      prev_out_in   = prev_out_ff;
      force_in      = force_ff;
      sched_in      = sched_ff;
      prev_sched_in = prev_sched_ff;
      ramp_in       = ramp_ff;
      level_in      = level_ff;
      timer_in      = timer_ff;
      tick_in       = tick_ff;
      result        = '0;

      ovr   = override_ff ^ item.toggle_request;
      fp    = force_ff | item.toggle_request | item.update_request;
      outst = 1'b0;
      upd   = 1'b0;

      if (enabled) begin
         ovr           = ovr & (schedule_in == prev_sched_ff);
         outst         = !item.on_battery & (schedule_in ^ ovr);
         upd           = (outst != prev_out_ff) || fp;
         prev_out_in   = outst;
         sched_in      = schedule_in;
         prev_sched_in = schedule_in;
         force_in      = 1'b0;
         if (upd) begin
            result.state_changed = 1'b1;
            result.duty_load     = 1'b1;
            if (outst) begin
               timer_in = STEP_RELOAD;
               level_in = '0;
               ramp_in  = 1'b1;
            end else begin
               ramp_in  = 1'b0;
            end
         end else if (ramp_ff && (item.tick_count != tick_ff)) begin
            tick_in = item.tick_count;
            if (timer_ff != '0) begin
               timer_in = timer_ff - 1'b1;
            end else if (level_ff >= target_brightness) begin
               ramp_in = 1'b0;
            end else begin
               level_in          = level_ff + 1'b1;
               timer_in          = STEP_RELOAD;
               result.duty_load  = 1'b1;
               result.duty_value = level_ff + 1'b1;
            end
         end
      end else begin
         force_in = fp;
      end
      override_in = ovr;

      result.output_on    = prev_out_in;
      result.target_state = sched_in ^ override_in;
      result.ramping      = ramp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         override_ff   <= 1'b0;
         prev_out_ff   <= 1'b0;
         force_ff      <= 1'b0;
         sched_ff      <= 1'b0;
         prev_sched_ff <= 1'b0;
         ramp_ff       <= 1'b0;
         level_ff      <= '0;
         timer_ff      <= '0;
         tick_ff       <= '0;
      end else if (fire) begin
         override_ff   <= override_in;
         prev_out_ff   <= prev_out_in;
         force_ff      <= force_in;
         sched_ff      <= sched_in;
         prev_sched_ff <= prev_sched_in;
         ramp_ff       <= ramp_in;
         level_ff      <= level_in;
         timer_ff      <= timer_in;
         tick_ff       <= tick_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/scheduled_led_output_with_ramp.sv -----
`default_nettype none

// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_ready  time, sun times, battery, tick, requests
// rsp_      out        rsp_valid / rsp_ready  change, output, target, duty, ramp flags
// csr_      in         csr_valid / csr_ready  csr_index, csr_data
//
// One beat per cycle sustained while rsp is not stalled.
// The input register feeds the schedule compare and state update, which load
// the result register. A stalled rsp holds the result; the input register
// still takes one more beat. Reset clears all controller state and restores
// the register defaults. csr_ready is always high.

module scheduled_led_output_with_ramp #(
   parameter int INTERVAL_COUNT  = sled_pkg::DEF_INTERVAL_COUNT,
   parameter int RAMP_STEP_TICKS = sled_pkg::DEF_RAMP_STEP_TICKS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,

   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [sled_pkg::MINUTE_W-1:0]     req_minutes_now,
   input  wire logic [sled_pkg::MINUTE_W-1:0]     req_sunrise_minute,
   input  wire logic [sled_pkg::MINUTE_W-1:0]     req_sunset_minute,
   input  wire logic                              req_on_battery,
   input  wire logic [sled_pkg::TICK_W-1:0]       req_tick_count,
   input  wire logic                              req_toggle_request,
   input  wire logic                              req_update_request,

   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_state_changed,
   output logic                                   rsp_output_on,
   output logic                                   rsp_target_state,
   output logic                                   rsp_duty_load,
   output logic [sled_pkg::DUTY_W-1:0]            rsp_duty_value,
   output logic                                   rsp_ramping,

   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [sled_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [sled_pkg::INTERVAL_W-1:0]   csr_data
);

   logic                                               enabled_ff;
   logic                                               mode_ff;
   logic [sled_pkg::DUTY_W-1:0]                        target_ff;
   logic [INTERVAL_COUNT-1:0][sled_pkg::INTERVAL_W-1:0] intervals_ff;

   logic              in_valid_ff;
   sled_pkg::req_type in_ff;
   logic              out_valid_ff;
   sled_pkg::rsp_type out_ff;
   sled_pkg::rsp_type result;
   logic              schedule_on;
   logic              advance;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff   <= 1'b1;
         mode_ff      <= 1'b0;
         target_ff    <= '1;
         intervals_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            sled_pkg::CSR_ENABLED:        enabled_ff <= csr_data[0];
            sled_pkg::CSR_SCHEDULER_MODE: mode_ff    <= csr_data[0];
            sled_pkg::CSR_TARGET:         target_ff  <= csr_data[sled_pkg::DUTY_W-1:0];
            default: begin
               for (int i = 0; i < INTERVAL_COUNT; i++) begin
                  if (csr_index == sled_pkg::CSR_INTERVAL_BASE + sled_pkg::CSR_IDX_W'(i)) begin
                     intervals_ff[i] <= csr_data;
                  end
               end
            end
         endcase
      end
   end

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff.minutes_now    <= req_minutes_now;
         in_ff.sunrise_minute <= req_sunrise_minute;
         in_ff.sunset_minute  <= req_sunset_minute;
         in_ff.on_battery     <= req_on_battery;
         in_ff.tick_count     <= req_tick_count;
         in_ff.toggle_request <= req_toggle_request;
         in_ff.update_request <= req_update_request;
      end
   end

   sled_sched #(
      .INTERVAL_COUNT(INTERVAL_COUNT)
   ) u_sched (
      .intervals      (intervals_ff),
      .scheduler_mode (mode_ff),
      .minutes_now    (in_ff.minutes_now),
      .sunrise_minute (in_ff.sunrise_minute),
      .sunset_minute  (in_ff.sunset_minute),
      .schedule_on    (schedule_on)
   );

   sled_ctrl #(
      .RAMP_STEP_TICKS(RAMP_STEP_TICKS)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .fire              (advance),
      .item              (in_ff),
      .schedule_in       (schedule_on),
      .enabled           (enabled_ff),
      .target_brightness (target_ff),
      .result            (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_state_changed = out_ff.state_changed;
   assign rsp_output_on     = out_ff.output_on;
   assign rsp_target_state  = out_ff.target_state;
   assign rsp_duty_load     = out_ff.duty_load;
   assign rsp_duty_value    = out_ff.duty_value;
   assign rsp_ramping       = out_ff.ramping;

   a_ramp_needs_output: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ramping |-> rsp_output_on)
      else $error("ramp active with output off");

   a_duty_zero_unloaded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_duty_load |-> rsp_duty_value == '0)
      else $error("duty value without load");

   a_change_loads_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_state_changed |-> rsp_duty_load && rsp_duty_value == '0)
      else $error("state change without zero duty load");

   a_result_follows_item: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("processed beat lost");

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

   localparam int          CYCLE_LIMIT = 200000;
   localparam int          HOLD_CYCLES = 80;
   localparam logic [1:0]  SW_ZERO     = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                            req_valid          = 1'b0;
   logic                            req_ready;
   logic [sled_pkg::MINUTE_W-1:0]   req_minutes_now    = '0;
   logic [sled_pkg::MINUTE_W-1:0]   req_sunrise_minute = '0;
   logic [sled_pkg::MINUTE_W-1:0]   req_sunset_minute  = '0;
   logic                            req_on_battery     = 1'b0;
   logic [sled_pkg::TICK_W-1:0]     req_tick_count     = '0;
   logic                            req_toggle_request = 1'b0;
   logic                            req_update_request = 1'b0;

   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic                            rsp_state_changed;
   logic                            rsp_output_on;
   logic                            rsp_target_state;
   logic                            rsp_duty_load;
   logic [sled_pkg::DUTY_W-1:0]     rsp_duty_value;
   logic                            rsp_ramping;

   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [sled_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [sled_pkg::INTERVAL_W-1:0] csr_data  = '0;

   // configuration copy
   logic                            cfg_enabled = 1'b1;
   logic                            cfg_mode    = 1'b0;
   logic [sled_pkg::DUTY_W-1:0]     cfg_target  = 8'd255;
   logic [sled_pkg::INTERVAL_W-1:0] cfg_span [0:3] = '{default: '0};

   // controller state copy
   logic                            mask_override = 1'b0;
   logic                            out_state     = 1'b0;
   logic                            force_update  = 1'b0;
   logic                            sched_now     = 1'b0;
   logic                            sched_prev    = 1'b0;
   logic                            ramp_busy     = 1'b0;
   logic [sled_pkg::DUTY_W-1:0]     ramp_duty     = '0;
   logic [sled_pkg::TIMER_W-1:0]    ramp_wait     = '0;
   logic [sled_pkg::TICK_W-1:0]     tick_seen     = '0;

   sled_pkg::rsp_type     pending_outcomes [$];
   sled_pkg::rsp_type     want;
   int                    errors = 0;
   int                    cycle_count;
   int                    hold_count;
   logic                  quiet   = 1'b0;
   logic                  holding = 1'b0;
   event                  stall_go;

   scheduled_led_output_with_ramp dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_minutes_now    (req_minutes_now),
      .req_sunrise_minute (req_sunrise_minute),
      .req_sunset_minute  (req_sunset_minute),
      .req_on_battery     (req_on_battery),
      .req_tick_count     (req_tick_count),
      .req_toggle_request (req_toggle_request),
      .req_update_request (req_update_request),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_state_changed  (rsp_state_changed),
      .rsp_output_on      (rsp_output_on),
      .rsp_target_state   (rsp_target_state),
      .rsp_duty_load      (rsp_duty_load),
      .rsp_duty_value     (rsp_duty_value),
      .rsp_ramping        (rsp_ramping),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [sled_pkg::MINUTE_W-1:0] sun_offset_minute(
         input logic [sled_pkg::MINUTE_W-1:0] base, input logic [7:0] offs);
      int sum;
      sum = int'(base) + int'($signed(offs));
      if (sum < 0) begin
         sum = sum + sled_pkg::DAY_MINUTES;
      end else if (sum >= sled_pkg::DAY_MINUTES) begin
         sum = sum - sled_pkg::DAY_MINUTES;
      end
      return sled_pkg::MINUTE_W'(sum);
   endfunction

   function automatic logic [sled_pkg::MINUTE_W-1:0] switch_minute(
         input logic [sled_pkg::SWITCH_W-1:0] sw,
         input logic [sled_pkg::MINUTE_W-1:0] t_rise,
         input logic [sled_pkg::MINUTE_W-1:0] t_set);
      case (sw[20:19])
         sled_pkg::SW_FIXED:   return sw[18:8];
         sled_pkg::SW_SUNRISE: return sun_offset_minute(t_rise, sw[7:0]);
         sled_pkg::SW_SUNSET:  return sun_offset_minute(t_set, sw[7:0]);
         default:              return '0;
      endcase
   endfunction

   function automatic logic schedule_active(input logic [sled_pkg::MINUTE_W-1:0] t_now,
                                            input logic [sled_pkg::MINUTE_W-1:0] t_rise,
                                            input logic [sled_pkg::MINUTE_W-1:0] t_set);
      int i;
      logic [sled_pkg::MINUTE_W-1:0] t_on;
      logic [sled_pkg::MINUTE_W-1:0] t_off;
      if (cfg_mode) begin
         return 1'b0;
      end
      for (i = 0; i < sled_pkg::DEF_INTERVAL_COUNT; i++) begin
         if (!cfg_span[i][42]) begin
            continue;
         end
         t_on  = switch_minute(cfg_span[i][41:21], t_rise, t_set);
         t_off = switch_minute(cfg_span[i][20:0], t_rise, t_set);
         if (t_on <= t_off) begin
            if (t_now >= t_on && t_now < t_off) begin
               return 1'b1;
            end
         end else if (t_now >= t_on || t_now < t_off) begin
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic sled_pkg::rsp_type predict_poll(input sled_pkg::req_type p);
      sled_pkg::rsp_type o;
      logic    lit;
      logic    refresh;
      o = '0;
      if (p.toggle_request) begin
         mask_override = ~mask_override;
         force_update  = 1'b1;
      end
      if (p.update_request) begin
         force_update = 1'b1;
      end
      if (cfg_enabled) begin
         sched_now     = schedule_active(p.minutes_now, p.sunrise_minute, p.sunset_minute);
         mask_override = mask_override & (sched_now == sched_prev);
         lit           = !p.on_battery && (sched_now ^ mask_override);
         refresh       = (lit != out_state) || force_update;
         out_state     = lit;
         sched_prev    = sched_now;
         force_update  = 1'b0;
         if (refresh) begin
            o.state_changed = 1'b1;
            o.duty_load     = 1'b1;
            if (lit) begin
               ramp_wait = sled_pkg::TIMER_W'(sled_pkg::DEF_RAMP_STEP_TICKS);
               ramp_duty = '0;
               ramp_busy = 1'b1;
            end else begin
               ramp_busy = 1'b0;
            end
         end else if (ramp_busy && p.tick_count != tick_seen) begin
            tick_seen = p.tick_count;
            if (ramp_wait != 0) begin
               ramp_wait = ramp_wait - 1'b1;
            end else if (ramp_duty >= cfg_target) begin
               ramp_busy = 1'b0;
            end else begin
               ramp_duty    = ramp_duty + 1'b1;
               ramp_wait    = sled_pkg::TIMER_W'(sled_pkg::DEF_RAMP_STEP_TICKS);
               o.duty_load  = 1'b1;
               o.duty_value = ramp_duty;
            end
         end
      end
      o.output_on    = out_state;
      o.target_state = sched_now ^ mask_override;
      o.ramping      = ramp_busy;
      return o;
   endfunction

   function automatic sled_pkg::req_type make_poll(input logic [sled_pkg::MINUTE_W-1:0] t_now,
                                                   input logic [sled_pkg::MINUTE_W-1:0] t_rise,
                                                   input logic [sled_pkg::MINUTE_W-1:0] t_set,
                                                   input logic batt,
                                                   input logic [sled_pkg::TICK_W-1:0] tick,
                                                   input logic tog, input logic upd);
      sled_pkg::req_type p;
      p.minutes_now    = t_now;
      p.sunrise_minute = t_rise;
      p.sunset_minute  = t_set;
      p.on_battery     = batt;
      p.tick_count     = tick;
      p.toggle_request = tog;
      p.update_request = upd;
      return p;
   endfunction

   function automatic logic [sled_pkg::SWITCH_W-1:0] pack_switch(
         input logic [1:0] kind, input logic [sled_pkg::MINUTE_W-1:0] mins,
         input logic [7:0] offs);
      return {kind, mins, offs};
   endfunction

   function automatic logic [sled_pkg::SWITCH_W-1:0] rand_switch();
      logic [sled_pkg::MINUTE_W-1:0] mins;
      if ($urandom_range(0, 9) == 0) begin
         mins = sled_pkg::MINUTE_W'($urandom_range(0, 2047));
      end else begin
         mins = sled_pkg::MINUTE_W'($urandom_range(0, 1439));
      end
      return pack_switch(2'($urandom_range(0, 3)), mins, 8'($urandom()));
   endfunction

   task automatic post_poll(input sled_pkg::req_type p);
      while (!quiet && $urandom_range(0, 99) < 35) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_minutes_now    <= p.minutes_now;
      req_sunrise_minute <= p.sunrise_minute;
      req_sunset_minute  <= p.sunset_minute;
      req_on_battery     <= p.on_battery;
      req_tick_count     <= p.tick_count;
      req_toggle_request <= p.toggle_request;
      req_update_request <= p.update_request;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      pending_outcomes.push_back(predict_poll(p));
   endtask

   task automatic write_reg(input logic [sled_pkg::CSR_IDX_W-1:0] idx,
                            input logic [sled_pkg::INTERVAL_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      csr_valid <= 1'b0;
      case (idx)
         sled_pkg::CSR_ENABLED:        cfg_enabled = val[0];
         sled_pkg::CSR_SCHEDULER_MODE: cfg_mode    = val[0];
         sled_pkg::CSR_TARGET:         cfg_target  = val[sled_pkg::DUTY_W-1:0];
         default: begin
            if (idx >= sled_pkg::CSR_INTERVAL_BASE &&
                idx < sled_pkg::CSR_INTERVAL_BASE + 3'd4) begin
               cfg_span[2'(idx - sled_pkg::CSR_INTERVAL_BASE)] = val;
            end
         end
      endcase
      @(posedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [7:0] exp_v,
                              input logic [7:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_outcomes.size() == 0) begin
            $display("%0t: result beat with nothing expected", $time);
            errors++;
         end else begin
            want = pending_outcomes.pop_front();
            check_field("state_changed", 8'(want.state_changed), 8'(rsp_state_changed));
            check_field("output_on", 8'(want.output_on), 8'(rsp_output_on));
            check_field("target_state", 8'(want.target_state), 8'(rsp_target_state));
            check_field("duty_load", 8'(want.duty_load), 8'(rsp_duty_load));
            check_field("duty_value", want.duty_value, rsp_duty_value);
            check_field("ramping", 8'(want.ramping), 8'(rsp_ramping));
         end
      end
   end

   always @(posedge clock) begin
      if (holding) begin
         rsp_ready <= 1'b0;
      end else if (quiet) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= 35);
      end
   end

   // hold off the result side for a fixed stretch
   always begin
      @(stall_go);
      holding <= 1'b1;
      for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) begin
         @(posedge clock);
      end
      holding <= 1'b0;
   end

   task automatic test_directed_corners();
      post_poll(make_poll(0, 0, 0, 1'b0, 16'h0000, 1'b1, 1'b0));
      post_poll(make_poll(1439, 1439, 1439, 1'b0, 16'hFFFF, 1'b0, 1'b0));
      drain_results();
      write_reg(sled_pkg::CSR_INTERVAL_BASE,
                {1'b1, pack_switch(sled_pkg::SW_FIXED, 480, 0),
                 pack_switch(sled_pkg::SW_FIXED, 1020, 0)});
      write_reg(sled_pkg::CSR_INTERVAL_BASE + 3'd1,
                {1'b1, pack_switch(sled_pkg::SW_SUNSET, 0, 8'd30),
                 pack_switch(sled_pkg::SW_SUNRISE, 0, 8'hE2)});
      write_reg(sled_pkg::CSR_INTERVAL_BASE + 3'd2,
                {1'b1, pack_switch(sled_pkg::SW_SUNRISE, 0, 8'h01),
                 pack_switch(SW_ZERO, 11'h7FF, 8'hFF)});
      write_reg(sled_pkg::CSR_INTERVAL_BASE + 3'd3,
                {1'b0, pack_switch(sled_pkg::SW_FIXED, 0, 0),
                 pack_switch(sled_pkg::SW_FIXED, 1439, 0)});
      post_poll(make_poll(479, 360, 1200, 1'b0, 16'd1, 1'b0, 1'b0));
      post_poll(make_poll(480, 360, 1200, 1'b0, 16'd2, 1'b0, 1'b0));
      post_poll(make_poll(1019, 360, 1200, 1'b0, 16'd3, 1'b0, 1'b0));
      post_poll(make_poll(1020, 360, 1200, 1'b0, 16'd4, 1'b0, 1'b0));
      post_poll(make_poll(0, 1439, 1200, 1'b0, 16'd5, 1'b0, 1'b0));
      post_poll(make_poll(0, 0, 1200, 1'b0, 16'd6, 1'b0, 1'b0));
      post_poll(make_poll(100, 2047, 2047, 1'b0, 16'd7, 1'b0, 1'b0));
      post_poll(make_poll(2047, 360, 1200, 1'b0, 16'd8, 1'b0, 1'b0));
      post_poll(make_poll(1439, 360, 1200, 1'b1, 16'd9, 1'b0, 1'b0));
      post_poll(make_poll(1439, 360, 1200, 1'b0, 16'd10, 1'b1, 1'b0));
      post_poll(make_poll(1439, 360, 1200, 1'b0, 16'd11, 1'b0, 1'b1));
      post_poll(make_poll(1439, 360, 1200, 1'b0, 16'd12, 1'b1, 1'b1));
      post_poll(make_poll(700, 100, 1439, 1'b0, 16'd13, 1'b0, 1'b0));
      post_poll(make_poll(1440, 360, 1200, 1'b0, 16'd14, 1'b0, 1'b0));
      drain_results();
      write_reg(sled_pkg::CSR_INTERVAL_BASE + 3'd3,
                {1'b1, pack_switch(sled_pkg::SW_SUNSET, 0, 8'h80),
                 pack_switch(sled_pkg::SW_SUNRISE, 0, 8'h7F)});
      post_poll(make_poll(1150, 400, 1200, 1'b0, 16'd15, 1'b0, 1'b0));
      post_poll(make_poll(10, 20, 50, 1'b0, 16'd16, 1'b0, 1'b0));
      post_poll(make_poll(1439, 1400, 0, 1'b0, 16'd17, 1'b1, 1'b0));
   endtask

   task automatic test_disabled_controller();
      drain_results();
      write_reg(sled_pkg::CSR_ENABLED, 0);
      post_poll(make_poll(600, 360, 1200, 1'b0, 16'd20, 1'b1, 1'b0));
      post_poll(make_poll(600, 360, 1200, 1'b0, 16'd21, 1'b0, 1'b1));
      post_poll(make_poll(10, 360, 1200, 1'b1, 16'd22, 1'b0, 1'b0));
      post_poll(make_poll(10, 360, 1200, 1'b0, 16'd23, 1'b1, 1'b1));
      drain_results();
      write_reg(sled_pkg::CSR_ENABLED, 1);
      post_poll(make_poll(600, 360, 1200, 1'b0, 16'd24, 1'b0, 1'b0));
      post_poll(make_poll(600, 360, 1200, 1'b0, 16'd25, 1'b0, 1'b0));
      post_poll(make_poll(10, 360, 1200, 1'b0, 16'd26, 1'b0, 1'b0));
   endtask

   task automatic test_scheduler_mode();
      drain_results();
      write_reg(sled_pkg::CSR_INTERVAL_BASE,
                {1'b1, pack_switch(sled_pkg::SW_FIXED, 0, 0),
                 pack_switch(sled_pkg::SW_FIXED,
                             sled_pkg::MINUTE_W'(sled_pkg::DAY_MINUTES), 0)});
      write_reg(sled_pkg::CSR_INTERVAL_BASE + 3'd1, {sled_pkg::INTERVAL_W{1'b1}});
      write_reg(sled_pkg::CSR_SCHEDULER_MODE, 1);
      post_poll(make_poll(600, 360, 1200, 1'b0, 16'd30, 1'b0, 1'b0));
      post_poll(make_poll(601, 360, 1200, 1'b0, 16'd31, 1'b1, 1'b0));
      post_poll(make_poll(602, 360, 1200, 1'b0, 16'd32, 1'b0, 1'b0));
      post_poll(make_poll(603, 360, 1200, 1'b0, 16'd33, 1'b1, 1'b0));
      drain_results();
      write_reg(sled_pkg::CSR_SCHEDULER_MODE, 0);
      post_poll(make_poll(604, 360, 1200, 1'b0, 16'd34, 1'b0, 1'b0));
      post_poll(make_poll(605, 360, 1200, 1'b0, 16'd35, 1'b1, 1'b0));
      post_poll(make_poll(606, 360, 1200, 1'b0, 16'd36, 1'b0, 1'b0));
   endtask

   task automatic test_brightness_ramp();
      logic [sled_pkg::TICK_W-1:0] tick;
      int                          n;
      drain_results();
      write_reg(sled_pkg::CSR_TARGET, 255);
      write_reg(sled_pkg::CSR_INTERVAL_BASE + 3'd1, '0);
      write_reg(sled_pkg::CSR_INTERVAL_BASE + 3'd2, '0);
      write_reg(sled_pkg::CSR_INTERVAL_BASE + 3'd3, '0);
      tick = 16'hFF00;
      // drop any manual override so that the output comes on
      post_poll(make_poll(600, 360, 1200, 1'b0, tick, mask_override, 1'b1));
      n = 0;
      // run the full ramp up to the top duty, wrapping the tick on the way
      while (ramp_busy && n < 1000) begin
         if ($urandom_range(0, 9) != 0) begin
            tick = tick + 1'b1;
         end
         post_poll(make_poll(600, 360, 1200, 1'b0, tick, 1'b0, 1'b0));
         n++;
      end
      drain_results();
      write_reg(sled_pkg::CSR_TARGET, 0);
      post_poll(make_poll(600, 360, 1200, 1'b0, tick, mask_override, 1'b1));
      for (n = 0; n < 10; n++) begin
         tick = tick + 1'b1;
         post_poll(make_poll(600, 360, 1200, 1'b0, tick, 1'b0, 1'b0));
      end
      drain_results();
      write_reg(sled_pkg::CSR_TARGET, 5);
      post_poll(make_poll(600, 360, 1200, 1'b0, tick, mask_override, 1'b1));
      for (n = 0; n < 40; n++) begin
         tick = tick + 1'b1;
         post_poll(make_poll(600, 360, 1200, (n == 7), tick, 1'b0, 1'b0));
      end
   endtask

   task automatic test_random_schedules();
      int                            phase;
      int                            n;
      int                            k;
      logic [sled_pkg::MINUTE_W-1:0] t_now;
      logic [sled_pkg::MINUTE_W-1:0] t_rise;
      logic [sled_pkg::MINUTE_W-1:0] t_set;
      logic [sled_pkg::TICK_W-1:0]   tick;
      logic                          batt;
      logic                          live;
      sled_pkg::req_type             p;
      for (phase = 0; phase < 8; phase++) begin
         drain_results();
         quiet <= (phase == 3);
         write_reg(sled_pkg::CSR_ENABLED,
                   sled_pkg::INTERVAL_W'($urandom_range(0, 9) != 0));
         write_reg(sled_pkg::CSR_SCHEDULER_MODE,
                   sled_pkg::INTERVAL_W'($urandom_range(0, 9) == 0));
         if (phase % 2 == 0) begin
            write_reg(sled_pkg::CSR_TARGET, sled_pkg::INTERVAL_W'($urandom_range(0, 12)));
         end else begin
            write_reg(sled_pkg::CSR_TARGET, sled_pkg::INTERVAL_W'($urandom_range(0, 255)));
         end
         for (k = 0; k < 4; k++) begin
            live = ($urandom_range(0, 6) != 0);
            if ($urandom_range(0, 9) == 0) begin
               write_reg(sled_pkg::CSR_INTERVAL_BASE + 3'(k),
                         sled_pkg::INTERVAL_W'({$urandom(), $urandom()}));
            end else begin
               write_reg(sled_pkg::CSR_INTERVAL_BASE + 3'(k),
                         {live, rand_switch(), rand_switch()});
            end
         end
         t_now  = sled_pkg::MINUTE_W'($urandom_range(0, 1439));
         t_rise = sled_pkg::MINUTE_W'($urandom_range(240, 480));
         t_set  = sled_pkg::MINUTE_W'($urandom_range(1000, 1300));
         tick   = sled_pkg::TICK_W'($urandom());
         batt   = 1'b0;
         for (n = 0; n < 90; n++) begin
            if ($urandom_range(0, 99) < 80) begin
               // advance the day slowly
               t_now = sled_pkg::MINUTE_W'((t_now + $urandom_range(0, 4)) %
                                           sled_pkg::DAY_MINUTES);
               tick  = tick + sled_pkg::TICK_W'($urandom_range(0, 2));
               if ($urandom_range(0, 99) < 3) begin
                  batt = ~batt;
               end
               p = make_poll(t_now, t_rise, t_set, batt, tick,
                             ($urandom_range(0, 99) < 4), ($urandom_range(0, 99) < 4));
            end else begin
               p = make_poll(sled_pkg::MINUTE_W'($urandom_range(0, 2047)),
                             sled_pkg::MINUTE_W'($urandom_range(0, 2047)),
                             sled_pkg::MINUTE_W'($urandom_range(0, 2047)),
                             1'($urandom_range(0, 1)), sled_pkg::TICK_W'($urandom()),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
            post_poll(p);
         end
      end
   endtask

   task automatic test_output_backpressure();
      logic [sled_pkg::TICK_W-1:0] tick;
      int                          n;
      drain_results();
      quiet <= 1'b1;
      write_reg(sled_pkg::CSR_ENABLED, 1);
      write_reg(sled_pkg::CSR_SCHEDULER_MODE, 0);
      write_reg(sled_pkg::CSR_TARGET, 3);
      write_reg(sled_pkg::CSR_INTERVAL_BASE,
                {1'b1, pack_switch(sled_pkg::SW_SUNSET, 0, 0),
                 pack_switch(sled_pkg::SW_SUNRISE, 0, 0)});
      -> stall_go;
      tick = '0;
      for (n = 0; n < 60; n++) begin
         tick = tick + 1'b1;
         post_poll(make_poll(sled_pkg::MINUTE_W'((n * 37) % sled_pkg::DAY_MINUTES),
                             360, 1200, 1'b0, tick, (n % 17 == 5), 1'b0));
      end
      quiet <= 1'b0;
   endtask

   initial begin
      for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) begin
         @(posedge clock);
      end
      $display("FAIL");
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_corners();
      test_disabled_controller();
      test_scheduler_mode();
      test_brightness_ramp();
      test_random_schedules();
      test_output_backpressure();
      drain_results();
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
